FILE: rtl/core/swcd_pkg.sv
package swcd_pkg;

    localparam int RX_BYTE_W = 8;
    localparam int WORD_W    = 16;
    localparam int STATUS_W  = 2;
    localparam int POS_W     = 3;

    // crc-8, msb first, no final xor
    localparam logic [7:0] CRC_INIT = 8'hFF;
    localparam logic [7:0] CRC_POLY = 8'h31;

    // check status codes
    localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FIRST_BAD  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_SECOND_BAD = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_UNUSED     = 2'd3;

    // byte position codes within one reply
    localparam logic [POS_W-1:0] POS_FIRST_HI   = 3'd0;
    localparam logic [POS_W-1:0] POS_FIRST_LO   = 3'd1;
    localparam logic [POS_W-1:0] POS_FIRST_CRC  = 3'd2;
    localparam logic [POS_W-1:0] POS_SECOND_HI  = 3'd3;
    localparam logic [POS_W-1:0] POS_SECOND_LO  = 3'd4;
    localparam logic [POS_W-1:0] POS_SECOND_CRC = 3'd5;

    typedef struct packed {
        logic [WORD_W-1:0]   first_word;
        logic [WORD_W-1:0]   second_word;
        logic [STATUS_W-1:0] status;
    } t_result;

    // one byte through the crc, eight shift steps of xor logic
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

FILE: rtl/core/swcd_frame_ctrl.sv
module swcd_frame_ctrl (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_accept,
    input  logic [swcd_pkg::RX_BYTE_W-1:0]     i_rx_byte,
    input  logic                               i_frame_start,
    output logic                               o_result_valid,
    output swcd_pkg::t_result                  o_result
);

    logic [swcd_pkg::POS_W-1:0]  r_pos, n_pos;
    logic [7:0]                  r_crc, n_crc;
    logic [swcd_pkg::WORD_W-1:0] r_first, n_first;
    logic [7:0]                  r_second_hi, n_second_hi;
    logic [7:0]                  r_second_lo, n_second_lo;
    logic                        r_first_bad, n_first_bad;

    logic [swcd_pkg::POS_W-1:0]  v_pos;
    logic [7:0]                  v_crc_seed;
    logic [7:0]                  v_crc_next;
    logic                        v_last;

    // restart and unreachable positions map to the first byte
    assign v_pos = (i_frame_start || (r_pos > swcd_pkg::POS_SECOND_CRC))
                   ? swcd_pkg::POS_FIRST_HI : r_pos;
    assign v_crc_seed = (v_pos == swcd_pkg::POS_FIRST_HI) ? swcd_pkg::CRC_INIT : r_crc;
    assign v_crc_next = swcd_pkg::crc8_byte(v_crc_seed, i_rx_byte);

    always_comb begin
        n_pos       = r_pos;
        n_crc       = r_crc;
        n_first     = r_first;
        n_second_hi = r_second_hi;
        n_second_lo = r_second_lo;
        n_first_bad = r_first_bad;
        v_last      = 1'b0;
        unique case (v_pos)
            swcd_pkg::POS_FIRST_HI: begin
                n_crc   = v_crc_next;
                n_first = {i_rx_byte, 8'h00};
                n_pos   = swcd_pkg::POS_FIRST_LO;
            end
            swcd_pkg::POS_FIRST_LO: begin
                n_crc        = v_crc_next;
                n_first[7:0] = i_rx_byte;
                n_pos        = swcd_pkg::POS_FIRST_CRC;
            end
            swcd_pkg::POS_FIRST_CRC: begin
                n_first_bad = (r_crc != i_rx_byte);
                n_crc       = swcd_pkg::CRC_INIT;
                n_pos       = swcd_pkg::POS_SECOND_HI;
            end
            swcd_pkg::POS_SECOND_HI: begin
                n_crc       = v_crc_next;
                n_second_hi = i_rx_byte;
                n_pos       = swcd_pkg::POS_SECOND_LO;
            end
            swcd_pkg::POS_SECOND_LO: begin
                n_crc       = v_crc_next;
                n_second_lo = i_rx_byte;
                n_pos       = swcd_pkg::POS_SECOND_CRC;
            end
            swcd_pkg::POS_SECOND_CRC: begin
                v_last = 1'b1;
                n_crc  = swcd_pkg::CRC_INIT;
                n_pos  = swcd_pkg::POS_FIRST_HI;
            end
            default: begin
                n_crc = swcd_pkg::CRC_INIT;
                n_pos = swcd_pkg::POS_FIRST_HI;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= swcd_pkg::POS_FIRST_HI;
            r_crc <= swcd_pkg::CRC_INIT;
        end else if (i_accept) begin
            r_pos <= n_pos;
            r_crc <= n_crc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_first     <= n_first;
            r_second_hi <= n_second_hi;
            r_second_lo <= n_second_lo;
            r_first_bad <= n_first_bad;
        end
    end

    assign o_result_valid       = i_accept && v_last;
    assign o_result.first_word  = r_first;
    assign o_result.second_word = {r_second_hi, r_second_lo};
    // first word error wins over second
    assign o_result.status = r_first_bad ? swcd_pkg::STATUS_FIRST_BAD
                           : (r_crc != i_rx_byte) ? swcd_pkg::STATUS_SECOND_BAD
                           : swcd_pkg::STATUS_OK;

endmodule

FILE: rtl/core/swcd_out_stage.sv
module swcd_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  swcd_pkg::t_result i_result,
    input  logic              i_ready,
    output logic              o_can_accept,
    output logic              o_valid,
    output swcd_pkg::t_result o_result
);

    logic              r_valid, n_valid;
    swcd_pkg::t_result r_result;

    assign o_can_accept = !r_valid || i_ready;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

FILE: rtl/core/sensor_word_crc_deframer.sv
// sensor reply deframer with per-word crc-8 check
//
// input stream: one reply byte per transaction. s tdata carries the byte,
// s tuser flags the first byte of a new reply and drops any partial one.
// a reply is six bytes: word 0 high, low, crc, word 1 high, low, crc.
// output stream: one transaction per complete reply, carrying both words
// in tdata and the check status in tuser (0 ok, 1 first word crc bad,
// 2 second word crc bad; a bad first word wins).
// throughput: one byte per cycle while s tready is high; the crc update is one byte of xor logic
// between the byte position/crc registers and the result register.
// latency: the result shows on the master side the cycle after the sixth
// byte is accepted.
// stall: the result register holds while m tready is low; while it holds a
// result and m tready is low, s tready is low for every byte, so the slave
// side stalls exactly while a result is pending and the receiver stalls.
// reset: synchronous, active low; clears the byte position, restarts the
// crc and empties the result register.
module sensor_word_crc_deframer (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // slave side
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  logic [swcd_pkg::RX_BYTE_W-1:0]      i_s_axis_tdata,   // [7:0] rx_byte
    input  logic                                i_s_axis_tuser,   // [0] frame_start
    // master side
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    output logic [2*swcd_pkg::WORD_W-1:0]       o_m_axis_tdata,   // [15:0] first_word,
                                                                  // [31:16] second_word
    output logic [swcd_pkg::STATUS_W-1:0]       o_m_axis_tuser    // [1:0] status
);

    logic              s_accept;
    logic              can_accept;
    logic              result_valid;
    swcd_pkg::t_result frame_result;
    swcd_pkg::t_result out_result;

    // a byte is taken whenever the result register can take a new result
    assign o_s_axis_tready = can_accept;
    assign s_accept        = i_s_axis_tvalid && can_accept;

    // byte position, running crc and held word bytes
    swcd_frame_ctrl u_frame_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (s_accept),
        .i_rx_byte      (i_s_axis_tdata),
        .i_frame_start  (i_s_axis_tuser),
        .o_result_valid (result_valid),
        .o_result       (frame_result)
    );

    // result register toward the master side
    swcd_out_stage u_out_stage (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (result_valid),
        .i_result     (frame_result),
        .i_ready      (i_m_axis_tready),
        .o_can_accept (can_accept),
        .o_valid      (o_m_axis_tvalid),
        .o_result     (out_result)
    );

    assign o_m_axis_tdata = {out_result.second_word, out_result.first_word};
    assign o_m_axis_tuser = out_result.status;

endmodule

FILE: rtl/core/swcd_checker.sv
module swcd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic        i_s_axis_tuser,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [31:0] o_m_axis_tdata,
    input logic [1:0]  o_m_axis_tuser
);

    // a stalled result holds its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
            (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)))
        else $error("result changed while stalled");

    // the unused status code is never shown
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tuser != swcd_pkg::STATUS_UNUSED))
        else $error("unused status code on output");

    // a new result needs a byte without the frame start flag accepted in the cycle before
    a_result_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !$past(o_m_axis_tvalid && !i_m_axis_tready)) |->
            $past(i_s_axis_tvalid && o_s_axis_tready && !i_s_axis_tuser))
        else $error("result without a closing byte");

    // reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind sensor_word_crc_deframer swcd_checker u_swcd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tuser  (i_s_axis_tuser),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);
